@@ rtl/core/r2q_pkg.sv @@
// ----------------------------------------------------------------------------
// r2q_pkg: shared types and constants for the rotation matrix to quaternion
// block. Holds the item passed from the front end to the back end.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package r2q_pkg;

  // Q1.14 one
  localparam int QONE = 16384;

  // Default depth of the front-to-back queue
  localparam int FIFO_DEPTH_DEF = 4;

  // Picked component codes
  typedef enum logic [1:0] {
    PICK_W = 2'd0,
    PICK_X = 2'd1,
    PICK_Y = 2'd2,
    PICK_Z = 2'd3
  } pick_t;

  // Classified item: picked candidate and the three pair terms, ordered by
  // the components that are not picked (w, x, y, z order).
  typedef struct packed {
    logic            bad;
    pick_t           best;
    logic [16:0]     s;
    logic [2:0][16:0] d;
  } fr_item_t;

  localparam int ITEM_W = $bits(fr_item_t);

endpackage

`default_nettype wire

@@ rtl/core/r2q_front.sv @@
// ----------------------------------------------------------------------------
// r2q_front: candidate formation and selection
// Forms the four trace candidates, picks the largest and routes the pair terms
// that belong to it. One register stage.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module r2q_front
  import r2q_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output      logic               in_ready,
  input  wire logic signed [15:0] in_r00,
  input  wire logic signed [15:0] in_r01,
  input  wire logic signed [15:0] in_r02,
  input  wire logic signed [15:0] in_r10,
  input  wire logic signed [15:0] in_r11,
  input  wire logic signed [15:0] in_r12,
  input  wire logic signed [15:0] in_r20,
  input  wire logic signed [15:0] in_r21,
  input  wire logic signed [15:0] in_r22,
  output      logic               fr_valid,
  input  wire logic               fr_ready,
  output      fr_item_t           fr_item
);

  logic               vld_r;
  fr_item_t           item_r;
  fr_item_t           item_nxt;
  logic signed [18:0] s0, s1, s2, s3, sb;
  logic signed [16:0] dw, ey, fz, pxy, pxz, pyz;
  logic signed [18:0] a00, a11, a22, one;

  assign in_ready = !vld_r || fr_ready;
  assign fr_valid = vld_r;
  assign fr_item  = item_r;

  // candidates and pair terms
  always_comb begin
    one = 19'(QONE);
    a00 = 19'(in_r00);
    a11 = 19'(in_r11);
    a22 = 19'(in_r22);
    s0  = one + a00 + a11 + a22;
    s1  = one + a00 - a11 - a22;
    s2  = one - a00 + a11 - a22;
    s3  = one - a00 - a11 + a22;
    dw  = 17'(in_r21) - 17'(in_r12);
    ey  = 17'(in_r02) - 17'(in_r20);
    fz  = 17'(in_r10) - 17'(in_r01);
    pxy = 17'(in_r01) + 17'(in_r10);
    pxz = 17'(in_r02) + 17'(in_r20);
    pyz = 17'(in_r12) + 17'(in_r21);

    // strict compare keeps the lower index on a tie
    item_nxt.best = PICK_W;
    sb            = s0;
    if (s1 > sb) begin
      item_nxt.best = PICK_X;
      sb            = s1;
    end
    if (s2 > sb) begin
      item_nxt.best = PICK_Y;
      sb            = s2;
    end
    if (s3 > sb) begin
      item_nxt.best = PICK_Z;
      sb            = s3;
    end
    item_nxt.bad = (sb <= 19'sd0);
    item_nxt.s   = item_nxt.bad ? 17'd0 : sb[16:0];

    unique case (item_nxt.best)
      PICK_W: item_nxt.d = {fz, ey, dw};
      PICK_X: item_nxt.d = {pxz, pxy, dw};
      PICK_Y: item_nxt.d = {pyz, pxy, ey};
      PICK_Z: item_nxt.d = {pyz, pxz, fz};
      default: item_nxt.d = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (in_ready) begin
      vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      item_r <= item_nxt;
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/r2q_fifo.sv @@
// ----------------------------------------------------------------------------
// r2q_fifo: short queue between front and back
// Register-based FIFO with valid/ready on both sides.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module r2q_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             wr_valid,
  output      logic             wr_ready,
  input  wire logic [WIDTH-1:0] wr_data,
  output      logic             rd_valid,
  input  wire logic             rd_ready,
  output      logic [WIDTH-1:0] rd_data
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PW-1:0]    wp_r, rp_r;
  logic [CW-1:0]    cnt_r;
  logic             push, pop;

  assign wr_ready = (cnt_r != CW'(DEPTH));
  assign rd_valid = (cnt_r != '0);
  assign rd_data  = mem_r[rp_r];
  assign push     = wr_valid && wr_ready;
  assign pop      = rd_valid && rd_ready;

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) begin
        wp_r <= (wp_r == PW'(DEPTH - 1)) ? '0 : wp_r + 1'b1;
      end
      if (pop) begin
        rp_r <= (rp_r == PW'(DEPTH - 1)) ? '0 : rp_r + 1'b1;
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (pop && !push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r] <= wr_data;
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/r2q_back.sv @@
// ----------------------------------------------------------------------------
// r2q_back: square root and scaling pipeline
// 15-stage digit-by-digit square root, then three 23-stage long dividers in
// parallel, then rounding/saturation into the output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module r2q_back
  import r2q_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               fr_valid,
  output      logic               fr_ready,
  input  wire fr_item_t           fr_item,
  output      logic               out_valid,
  input  wire logic               out_ready,
  output      logic signed [15:0] out_q_w,
  output      logic signed [15:0] out_q_x,
  output      logic signed [15:0] out_q_y,
  output      logic signed [15:0] out_q_z,
  output      logic               out_not_rotation
);

  localparam int SQ_N = 15;  // root bits
  localparam int DV_N = 23;  // quotient bits

  typedef struct packed {
    logic             bad;
    pick_t            best;
    logic [2:0][16:0] d;
    logic [29:0]      v;
    logic [17:0]      rem;
    logic [14:0]      root;
  } sq_t;

  typedef struct packed {
    logic             bad;
    pick_t            best;
    logic [14:0]      c;
    logic [2:0]       neg;
    logic [2:0][22:0] num;
    logic [2:0][16:0] rem;
    logic [2:0][22:0] quo;
  } dv_t;

  sq_t          sq_r   [SQ_N+1];
  sq_t          sq_nxt [SQ_N+1];
  logic         sq_vld_r [SQ_N+1];
  dv_t          dv_r   [DV_N+1];
  dv_t          dv_nxt [DV_N+1];
  logic         dv_vld_r [DV_N+1];
  logic [17:0]  s_rem2 [SQ_N];
  logic [17:0]  s_trial[SQ_N];
  logic [16:0]  d_rem2 [DV_N][3];
  logic [16:0]  mag    [3];
  logic [29:0]  nfull  [3];
  logic         en;
  logic         out_vld_r;
  logic [3:0][15:0] q_r, q_nxt;
  logic         bad_r;
  logic [2:0][15:0] qs;

  // whole pipeline advances unless the output is held
  assign en        = !out_vld_r || out_ready;
  assign fr_ready  = en;
  assign out_valid = out_vld_r;
  assign out_q_w   = q_r[0];
  assign out_q_x   = q_r[1];
  assign out_q_y   = q_r[2];
  assign out_q_z   = q_r[3];
  assign out_not_rotation = bad_r;

  // apply the sign to a divider result and saturate to Q1.14
  function automatic logic [15:0] sat_q(input logic neg, input logic [22:0] q);
    logic [15:0] r;
    if (neg) begin
      r = (q > 23'd32768) ? 16'h8000 : 16'(~q + 23'd1);
    end else begin
      r = (q > 23'd32767) ? 16'h7fff : q[15:0];
    end
    return r;
  endfunction

  // square root steps: two radicand bits per stage
  always_comb begin
    sq_nxt[0].bad  = fr_item.bad;
    sq_nxt[0].best = fr_item.best;
    sq_nxt[0].d    = fr_item.d;
    sq_nxt[0].v    = {1'b0, fr_item.s, 12'b0};
    sq_nxt[0].rem  = '0;
    sq_nxt[0].root = '0;
    for (int k = 0; k < SQ_N; k++) begin
      sq_nxt[k+1]   = sq_r[k];
      s_rem2[k]     = {sq_r[k].rem[15:0], sq_r[k].v[29:28]};
      s_trial[k]    = {1'b0, sq_r[k].root, 2'b01};
      sq_nxt[k+1].v = {sq_r[k].v[27:0], 2'b00};
      if (s_rem2[k] >= s_trial[k]) begin
        sq_nxt[k+1].rem  = s_rem2[k] - s_trial[k];
        sq_nxt[k+1].root = {sq_r[k].root[13:0], 1'b1};
      end else begin
        sq_nxt[k+1].rem  = s_rem2[k];
        sq_nxt[k+1].root = {sq_r[k].root[13:0], 1'b0};
      end
    end
  end

  // divider setup: numerator 2*|d|*4096 + c, divisor 2*c
  always_comb begin
    dv_nxt[0].bad  = sq_r[SQ_N].bad;
    dv_nxt[0].best = sq_r[SQ_N].best;
    dv_nxt[0].c    = sq_r[SQ_N].root;
    for (int i = 0; i < 3; i++) begin
      dv_nxt[0].neg[i] = sq_r[SQ_N].d[i][16];
      mag[i]   = sq_r[SQ_N].d[i][16] ? (~sq_r[SQ_N].d[i] + 17'd1) : sq_r[SQ_N].d[i];
      nfull[i] = {mag[i], 13'b0} + {15'b0, sq_r[SQ_N].root};
      dv_nxt[0].rem[i] = {10'b0, nfull[i][29:23]};
      dv_nxt[0].num[i] = nfull[i][22:0];
      dv_nxt[0].quo[i] = '0;
    end
    for (int k = 0; k < DV_N; k++) begin
      dv_nxt[k+1] = dv_r[k];
      for (int i = 0; i < 3; i++) begin
        d_rem2[k][i] = {dv_r[k].rem[i][15:0], dv_r[k].num[i][22]};
        dv_nxt[k+1].num[i] = {dv_r[k].num[i][21:0], 1'b0};
        if (d_rem2[k][i] >= {1'b0, dv_r[k].c, 1'b0}) begin
          dv_nxt[k+1].rem[i] = d_rem2[k][i] - {1'b0, dv_r[k].c, 1'b0};
          dv_nxt[k+1].quo[i] = {dv_r[k].quo[i][21:0], 1'b1};
        end else begin
          dv_nxt[k+1].rem[i] = d_rem2[k][i];
          dv_nxt[k+1].quo[i] = {dv_r[k].quo[i][21:0], 1'b0};
        end
      end
    end
  end

  // output assembly by picked component
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      qs[i] = sat_q(dv_r[DV_N].neg[i], dv_r[DV_N].quo[i]);
    end
    q_nxt = '0;
    unique case (dv_r[DV_N].best)
      PICK_W: q_nxt = {qs[2], qs[1], qs[0], {1'b0, dv_r[DV_N].c}};
      PICK_X: q_nxt = {qs[2], qs[1], {1'b0, dv_r[DV_N].c}, qs[0]};
      PICK_Y: q_nxt = {qs[2], {1'b0, dv_r[DV_N].c}, qs[1], qs[0]};
      PICK_Z: q_nxt = {{1'b0, dv_r[DV_N].c}, qs[2], qs[1], qs[0]};
      default: q_nxt = '0;
    endcase
    if (dv_r[DV_N].bad) begin
      q_nxt = '0;
    end
  end

  // valid tracking
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k <= SQ_N; k++) sq_vld_r[k] <= 1'b0;
      for (int k = 0; k <= DV_N; k++) dv_vld_r[k] <= 1'b0;
      out_vld_r <= 1'b0;
    end else if (en) begin
      sq_vld_r[0] <= fr_valid;
      for (int k = 0; k < SQ_N; k++) sq_vld_r[k+1] <= sq_vld_r[k];
      dv_vld_r[0] <= sq_vld_r[SQ_N];
      for (int k = 0; k < DV_N; k++) dv_vld_r[k+1] <= dv_vld_r[k];
      out_vld_r <= dv_vld_r[DV_N];
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k <= SQ_N; k++) sq_r[k] <= sq_nxt[k];
      for (int k = 0; k <= DV_N; k++) dv_r[k] <= dv_nxt[k];
      q_r   <= q_nxt;
      bad_r <= dv_r[DV_N].bad;
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/rotation_matrix_to_quaternion.sv @@
// ----------------------------------------------------------------------------
// rotation_matrix_to_quaternion: Q1.14 rotation matrix to unit quaternion
//
// Input channel in_valid/in_ready carries nine Q1.14 matrix elements; output
// channel out_valid/out_ready carries q_w..q_z in Q1.14 and a not_rotation
// flag. The front end forms the four trace candidates and picks the largest;
// a short queue decouples it from the back end, which runs a 15-stage square
// root followed by three parallel 23-stage dividers and a rounding stage.
// Throughput is one item per cycle while the receiver does not stall, set
// by the fully pipelined root and dividers. Reset clears all valid state;
// no results are pending after it. When the receiver stalls, the back
// pipeline holds in place, the queue fills, and in_ready drops only once
// the queue and the front register are full.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rotation_matrix_to_quaternion
  import r2q_pkg::*;
#(
  parameter int FIFO_DEPTH = FIFO_DEPTH_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output      logic               in_ready,
  input  wire logic signed [15:0] in_r00,
  input  wire logic signed [15:0] in_r01,
  input  wire logic signed [15:0] in_r02,
  input  wire logic signed [15:0] in_r10,
  input  wire logic signed [15:0] in_r11,
  input  wire logic signed [15:0] in_r12,
  input  wire logic signed [15:0] in_r20,
  input  wire logic signed [15:0] in_r21,
  input  wire logic signed [15:0] in_r22,
  output      logic               out_valid,
  input  wire logic               out_ready,
  output      logic signed [15:0] out_q_w,
  output      logic signed [15:0] out_q_x,
  output      logic signed [15:0] out_q_y,
  output      logic signed [15:0] out_q_z,
  output      logic               out_not_rotation
);

  logic              f_valid, f_ready, b_valid, b_ready;
  fr_item_t          f_item, b_item;
  logic [ITEM_W-1:0] b_bits;

  r2q_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_r00   (in_r00),
    .in_r01   (in_r01),
    .in_r02   (in_r02),
    .in_r10   (in_r10),
    .in_r11   (in_r11),
    .in_r12   (in_r12),
    .in_r20   (in_r20),
    .in_r21   (in_r21),
    .in_r22   (in_r22),
    .fr_valid (f_valid),
    .fr_ready (f_ready),
    .fr_item  (f_item)
  );

  r2q_fifo #(
    .WIDTH (ITEM_W),
    .DEPTH (FIFO_DEPTH)
  ) u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_valid (f_valid),
    .wr_ready (f_ready),
    .wr_data  (f_item),
    .rd_valid (b_valid),
    .rd_ready (b_ready),
    .rd_data  (b_bits)
  );

  assign b_item = fr_item_t'(b_bits);

  r2q_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .fr_valid         (b_valid),
    .fr_ready         (b_ready),
    .fr_item          (b_item),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_q_w          (out_q_w),
    .out_q_x          (out_q_x),
    .out_q_y          (out_q_y),
    .out_q_z          (out_q_z),
    .out_not_rotation (out_not_rotation)
  );

endmodule

`default_nettype wire

@@ tb/rotation_matrix_to_quaternion_tb.sv @@
// ----------------------------------------------------------------------------
// rotation_matrix_to_quaternion_tb: self-checking bench for the Q1.14 matrix
// to quaternion block.
//
// Drives directed matrices (identity, half turns about each axis, ties, not
// rotations, saturating inputs) and then random rotations, perturbed ones and
// raw noise, with random idle bursts on both channels. A scoreboard class
// predicts each result and compares it field by field in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rotation_matrix_to_quaternion_tb
  import r2q_pkg::*;
();

  // Matrix and quaternion records
  typedef struct {
    logic signed [15:0] m [9];
  } matrix_t;

  typedef struct {
    logic signed [15:0] w, x, y, z;
    logic               nr;
  } quat_t;

  // Expected-quaternion store and checker
  class quat_scoreboard;
    quat_t pending_q[$];
    int    errors;
    int    checked;
    int    nr_seen;
    int    pick_seen[4];

    function automatic logic signed [15:0] clamp16(longint v);
      if (v > 32767) return 16'sh7fff;
      if (v < -32768) return 16'sh8000;
      return v[15:0];
    endfunction

    // Truncated square root, bit by bit
    function automatic longint root_floor(longint v);
      longint r;
      r = 0;
      for (int b = 15; b >= 0; b--) begin
        if ((r + (64'd1 << b)) * (r + (64'd1 << b)) <= v) r = r + (64'd1 << b);
      end
      return r;
    endfunction

    // d*4096/c rounded half away from zero
    function automatic logic signed [15:0] scaled_ratio(longint d, longint c);
      longint mag, q;
      mag = (d < 0 ? -d : d) * 4096;
      q = (2 * mag + c) / (2 * c);
      return clamp16(d < 0 ? -q : q);
    endfunction

    function automatic quat_t predict_quat(matrix_t a);
      longint r00, r01, r02, r10, r11, r12, r20, r21, r22;
      longint s[4];
      longint c, dw, ey, fz, pxy, pxz, pyz;
      logic signed [15:0] q[4];
      pick_t pick;
      quat_t res;
      r00 = a.m[0]; r01 = a.m[1]; r02 = a.m[2];
      r10 = a.m[3]; r11 = a.m[4]; r12 = a.m[5];
      r20 = a.m[6]; r21 = a.m[7]; r22 = a.m[8];
      s[0] = QONE + r00 + r11 + r22;
      s[1] = QONE + r00 - r11 - r22;
      s[2] = QONE - r00 + r11 - r22;
      s[3] = QONE - r00 - r11 + r22;
      pick = PICK_W;
      for (int i = 1; i < 4; i++) if (s[i] > s[pick]) pick = pick_t'(i);
      q = '{default: 16'sd0};
      res.nr = (s[pick] <= 0);
      if (!res.nr) begin
        pick_seen[pick]++;
        c = root_floor(s[pick] * 4096);
        dw = r21 - r12; ey = r02 - r20; fz = r10 - r01;
        pxy = r01 + r10; pxz = r02 + r20; pyz = r12 + r21;
        q[pick] = clamp16(c);
        case (pick)
          PICK_W: begin
            q[1] = scaled_ratio(dw, c); q[2] = scaled_ratio(ey, c);
            q[3] = scaled_ratio(fz, c);
          end
          PICK_X: begin
            q[0] = scaled_ratio(dw, c); q[2] = scaled_ratio(pxy, c);
            q[3] = scaled_ratio(pxz, c);
          end
          PICK_Y: begin
            q[0] = scaled_ratio(ey, c); q[1] = scaled_ratio(pxy, c);
            q[3] = scaled_ratio(pyz, c);
          end
          default: begin
            q[0] = scaled_ratio(fz, c); q[1] = scaled_ratio(pxz, c);
            q[2] = scaled_ratio(pyz, c);
          end
        endcase
      end else begin
        nr_seen++;
      end
      res.w = q[0]; res.x = q[1]; res.y = q[2]; res.z = q[3];
      return res;
    endfunction

    function void note_input(matrix_t a);
      pending_q.push_back(predict_quat(a));
    endfunction

    function void check_result(quat_t got);
      quat_t e;
      if (pending_q.size() == 0) begin
        errors++;
        if (errors <= 10) $display("ERROR: result with nothing pending");
        return;
      end
      e = pending_q.pop_front();
      checked++;
      if (got.w !== e.w || got.x !== e.x || got.y !== e.y || got.z !== e.z ||
          got.nr !== e.nr) begin
        errors++;
        if (errors <= 10)
          $display({"ERROR: result %0d exp w=%0d x=%0d y=%0d z=%0d nr=%b",
                    " got w=%0d x=%0d y=%0d z=%0d nr=%b"},
                   checked, e.w, e.x, e.y, e.z, e.nr,
                   got.w, got.x, got.y, got.z, got.nr);
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic signed [15:0] in_r [9] = '{default: 16'sd0};
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [15:0] out_q_w, out_q_x, out_q_y, out_q_z;
  logic out_not_rotation;

  quat_scoreboard board;
  bit   quiet_phase;
  int   cycles;
  int   sent;

  localparam int CYCLE_LIMIT = 200000;

  always #5 clk = ~clk;

  rotation_matrix_to_quaternion DUT (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_r00(in_r[0]), .in_r01(in_r[1]), .in_r02(in_r[2]),
    .in_r10(in_r[3]), .in_r11(in_r[4]), .in_r12(in_r[5]),
    .in_r20(in_r[6]), .in_r21(in_r[7]), .in_r22(in_r[8]),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_q_w(out_q_w), .out_q_x(out_q_x), .out_q_y(out_q_y),
    .out_q_z(out_q_z), .out_not_rotation(out_not_rotation)
  );

  // Send one matrix; optional idle burst before it
  task automatic send_matrix(matrix_t a);
    if (!quiet_phase && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    in_valid <= 1'b1;
    for (int i = 0; i < 9; i++) in_r[i] <= a.m[i];
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    board.note_input(a);
    sent++;
  endtask

  // Matrix builders
  function automatic matrix_t diag_matrix(int a, int b, int c);
    matrix_t r;
    r.m = '{default: 16'sd0};
    r.m[0] = 16'(a); r.m[4] = 16'(b); r.m[8] = 16'(c);
    return r;
  endfunction

  function automatic matrix_t noise_matrix();
    matrix_t r;
    for (int i = 0; i < 9; i++) r.m[i] = 16'($urandom());
    return r;
  endfunction

  // Rotation from a random quaternion, optionally nudged
  function automatic matrix_t rotation_matrix(int jitter);
    matrix_t r;
    real w, x, y, z, n;
    real f[9];
    w = $urandom_range(0, 2000) - 1000.0; x = $urandom_range(0, 2000) - 1000.0;
    y = $urandom_range(0, 2000) - 1000.0; z = $urandom_range(0, 2000) - 1000.0;
    n = $sqrt(w*w + x*x + y*y + z*z) + 1e-9;
    w /= n; x /= n; y /= n; z /= n;
    f[0] = 1 - 2*(y*y + z*z); f[1] = 2*(x*y - w*z); f[2] = 2*(x*z + w*y);
    f[3] = 2*(x*y + w*z); f[4] = 1 - 2*(x*x + z*z); f[5] = 2*(y*z - w*x);
    f[6] = 2*(x*z - w*y); f[7] = 2*(y*z + w*x); f[8] = 1 - 2*(x*x + y*y);
    for (int i = 0; i < 9; i++)
      r.m[i] = 16'($rtoi(f[i] * 16384.0) + $urandom_range(0, 2*jitter) - jitter);
    return r;
  endfunction

  // Receiver with random stall bursts
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && out_ready)
        board.check_result('{w: out_q_w, x: out_q_x, y: out_q_y, z: out_q_z,
                             nr: out_not_rotation});
    end
  end

  initial begin
    forever begin
      @(posedge clk);
      if (!quiet_phase && $urandom_range(0, 4) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 3)) @(posedge clk);
      end
      out_ready <= 1'b1;
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("rotation_matrix_to_quaternion verification failed");
      $finish;
    end
  end

  initial begin
    matrix_t a;
    board = new();
    cycles = 0;
    sent = 0;
    quiet_phase = 0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: identity, half turns, ties, not rotations, extremes
    send_matrix(diag_matrix(16384, 16384, 16384));
    send_matrix(diag_matrix(16384, -16384, -16384));
    send_matrix(diag_matrix(-16384, 16384, -16384));
    send_matrix(diag_matrix(-16384, -16384, 16384));
    send_matrix(diag_matrix(0, 0, 0));
    send_matrix(diag_matrix(-16384, -16384, -16384));
    send_matrix(diag_matrix(-32768, -32768, -32768));
    send_matrix(diag_matrix(32767, 32767, 32767));
    send_matrix(diag_matrix(-5462, -5461, -5461));
    send_matrix(diag_matrix(-5461, -5461, -5462));
    a = diag_matrix(-5461, -5461, -5461);
    a.m[1] = 16'sd32767; a.m[3] = 16'sd32767;
    a.m[2] = 16'sh8000; a.m[6] = 16'sh8000;
    send_matrix(a);
    a = diag_matrix(32767, -32768, -32768);
    a.m[1] = 16'sd32767; a.m[3] = 16'sd32767;
    a.m[5] = 16'sh8000; a.m[7] = 16'sd32767;
    send_matrix(a);
    a.m = '{default: 16'sh8000}; send_matrix(a);
    a.m = '{default: 16'sh7fff}; send_matrix(a);
    a.m = '{default: 16'shffff}; send_matrix(a);
    a = diag_matrix(-16383, -16383, -16383);
    a.m[7] = 16'sd32767; a.m[5] = 16'sh8000; a.m[2] = 16'sd32767;
    a.m[6] = 16'sh8000; a.m[3] = 16'sd32767; a.m[1] = 16'sh8000;
    send_matrix(a);
    a = diag_matrix(0, 0, -16384);
    a.m[1] = -16'sd16384; a.m[3] = 16'sd16384;
    send_matrix(a);

    // Random: mostly rotations, some perturbed, some noise
    for (int k = 0; k < 640; k++) begin
      if (k == 560) quiet_phase = 1;
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4: send_matrix(rotation_matrix(0));
        5, 6:          send_matrix(rotation_matrix($urandom_range(1, 300)));
        default:       send_matrix(noise_matrix());
      endcase
    end
    in_valid <= 1'b0;

    while (board.pending_q.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);

    $display("sent %0d matrices, checked %0d results, %0d not rotations",
             sent, board.checked, board.nr_seen);
    $display("picks w/x/y/z: %0d/%0d/%0d/%0d", board.pick_seen[0],
             board.pick_seen[1], board.pick_seen[2], board.pick_seen[3]);
    if (board.errors == 0 && board.pending_q.size() == 0)
      $display("rotation_matrix_to_quaternion verification clean");
    else
      $display("rotation_matrix_to_quaternion verification failed");
    $finish;
  end

endmodule

`default_nettype wire
